@@ design/qtva_pkg.sv @@
`default_nettype none

package qtva_pkg;

    // Batch length limit and the saturation point of the record counter
    localparam int unsigned MAX_BATCH_VERTICES = 65536;
    localparam logic [15:0] COUNT_CAP =
        16'(((MAX_BATCH_VERTICES - 1) < 65535) ? (MAX_BATCH_VERTICES - 1) : 65535);

    // Item queue between front and back (power of two, pointers wrap naturally)
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

    // Port widths
    localparam int unsigned S_TDATA_W  = 224;
    localparam int unsigned M_TDATA_W  = 264;
    localparam int unsigned CFG_ADDR_W = 5;

    // Register map, word index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_X_OFFSET    = 3'd0,
        REG_Y_OFFSET    = 3'd1,
        REG_Z_OFFSET    = 3'd2,
        REG_QUAD_MODE   = 3'd3,
        REG_SPLIT_QUADS = 3'd4,
        REG_ATTR_ENABLE = 3'd5
    } reg_index_t;

    // Attribute enable bits
    localparam int unsigned ATTR_TEX    = 0;
    localparam int unsigned ATTR_COLOR  = 1;
    localparam int unsigned ATTR_NORMAL = 2;
    localparam int unsigned ATTR_LIGHT  = 3;

    // Vertex positions within a quad that matter
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    // Rows of the kept-corner store
    localparam logic CORNER_FIRST_ROW = 1'b0;
    localparam logic CORNER_THIRD_ROW = 1'b1;

    // One vertex record as it leaves the block
    typedef struct packed {
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic [31:0] z_bits;
        logic [31:0] u;
        logic [31:0] v;
        logic [31:0] color;
        logic [23:0] normal;
        logic [31:0] light;
    } rec_t;

    // One classified vertex waiting in the queue
    typedef struct packed {
        logic               first;
        logic               expand;
        logic               keep;
        logic               keep_row;
        logic signed [23:0] sum_x;
        logic signed [23:0] sum_y;
        logic signed [23:0] sum_z;
        logic [31:0]        u;
        logic [31:0]        v;
        logic [31:0]        color;
        logic [23:0]        normal;
        logic [31:0]        light;
    } entry_t;

    // Which record of the head item goes out next
    typedef enum logic [1:0] {
        ST_LEAD   = 2'd0,
        ST_SECOND = 2'd1,
        ST_OWN    = 2'd2
    } emit_state_t;

endpackage

`default_nettype wire

@@ design/qtva_front.sv @@
`default_nettype none

module qtva_front (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, color_word, light_word, normal_word
    input  wire logic [qtva_pkg::S_TDATA_W-1:0] s_tdata,
    // first_of_batch
    input  wire logic                           s_tuser,
    input  wire logic signed [23:0]             x_offset,
    input  wire logic signed [23:0]             y_offset,
    input  wire logic signed [23:0]             z_offset,
    input  wire logic                           quad_mode,
    input  wire logic                           split_quads,
    input  wire logic [3:0]                     attr_enable,
    input  wire logic                           q_full,
    output logic                                push,
    output qtva_pkg::entry_t                    push_entry
);

    logic [1:0] quad_pos_reg;
    logic [1:0] quad_pos_next;
    logic [1:0] pos_now;

    // Add with saturation to the signed 24-bit range
    function automatic logic signed [23:0] sat_add(logic signed [23:0] a,
                                                   logic signed [23:0] b);
        logic signed [24:0] s;
        s = {a[23], a} + {b[23], b};
        if (s[24] != s[23]) begin
            return s[24] ? 24'sh800000 : 24'sh7FFFFF;
        end
        return s[23:0];
    endfunction

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Restart the quad on the first vertex of a batch
    assign pos_now = s_tuser ? qtva_pkg::QUAD_FIRST : quad_pos_reg;

    // Classify and translate the incoming item
    always_comb begin
        push_entry          = '0;
        push_entry.first    = s_tuser;
        push_entry.expand   = quad_mode && split_quads && (pos_now == qtva_pkg::QUAD_FOURTH);
        push_entry.keep     = (pos_now == qtva_pkg::QUAD_FIRST) ||
                              (pos_now == qtva_pkg::QUAD_THIRD);
        push_entry.keep_row = (pos_now == qtva_pkg::QUAD_THIRD) ? qtva_pkg::CORNER_THIRD_ROW
                                                                : qtva_pkg::CORNER_FIRST_ROW;
        push_entry.sum_x    = sat_add(s_tdata[23:0], x_offset);
        push_entry.sum_y    = sat_add(s_tdata[47:24], y_offset);
        push_entry.sum_z    = sat_add(s_tdata[71:48], z_offset);
        push_entry.u        = attr_enable[qtva_pkg::ATTR_TEX]    ? s_tdata[103:72]  : 32'd0;
        push_entry.v        = attr_enable[qtva_pkg::ATTR_TEX]    ? s_tdata[135:104] : 32'd0;
        push_entry.color    = attr_enable[qtva_pkg::ATTR_COLOR]  ? s_tdata[167:136] : 32'd0;
        push_entry.light    = attr_enable[qtva_pkg::ATTR_LIGHT]  ? s_tdata[199:168] : 32'd0;
        push_entry.normal   = attr_enable[qtva_pkg::ATTR_NORMAL] ? s_tdata[223:200] : 24'd0;
    end

    // Advance the quad position on every accepted item
    assign quad_pos_next = push ? (pos_now + 2'd1) : quad_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_pos_reg <= qtva_pkg::QUAD_FIRST;
        end else begin
            quad_pos_reg <= quad_pos_next;
        end
    end

endmodule

`default_nettype wire

@@ design/qtva_queue.sv @@
`default_nettype none

module qtva_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  qtva_pkg::entry_t       push_entry,
    input  wire logic              pop,
    output logic                   full,
    output logic                   empty,
    output qtva_pkg::entry_t       head
);

    qtva_pkg::entry_t q_mem [qtva_pkg::QUEUE_DEPTH];

    logic [qtva_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [qtva_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [qtva_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [qtva_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [qtva_pkg::QPTR_W:0]   count_reg;
    logic [qtva_pkg::QPTR_W:0]   count_next;

    assign full  = (count_reg == (qtva_pkg::QPTR_W + 1)'(qtva_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = q_mem[rd_ptr_reg];

    // Move pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? (wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

@@ design/qtva_back.sv @@
`default_nettype none

module qtva_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           head_valid,
    input  qtva_pkg::entry_t                    head,
    input  wire logic [3:0]                     attr_enable,
    output logic                                pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [qtva_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast
);

    qtva_pkg::emit_state_t st_reg;
    qtva_pkg::emit_state_t st_next;
    logic [15:0]           count_reg;
    logic [15:0]           count_next;
    qtva_pkg::rec_t        corner_reg [2];
    logic                  m_tvalid_reg;
    logic [qtva_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                  m_tlast_reg;

    logic                  load;
    logic                  is_replay;
    logic                  corner_row;
    qtva_pkg::rec_t        own_rec;
    qtva_pkg::rec_t        replay_rec;
    qtva_pkg::rec_t        rec_sel;
    logic [15:0]           rec_index;

    // Exact conversion of a signed 24-bit Q16.8 value to single-precision bits
    function automatic logic [31:0] to_float(logic signed [23:0] s);
        logic [23:0] mag;
        logic [4:0]  lz;
        logic [23:0] norm;
        logic [7:0]  expo;
        mag = s[23] ? (~s + 24'd1) : s;
        lz  = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (mag[i]) begin
                lz = 5'(23 - i);
            end
        end
        norm = mag << lz;
        expo = 8'd142 - {3'b000, lz};
        if (mag == 24'd0) begin
            return 32'd0;
        end
        return {s[23], expo, norm[22:0]};
    endfunction

    // Zero the attributes that are disabled now
    function automatic qtva_pkg::rec_t mask_attrs(qtva_pkg::rec_t r, logic [3:0] en);
        qtva_pkg::rec_t m;
        m = r;
        if (!en[qtva_pkg::ATTR_TEX]) begin
            m.u = 32'd0;
            m.v = 32'd0;
        end
        if (!en[qtva_pkg::ATTR_COLOR]) begin
            m.color = 32'd0;
        end
        if (!en[qtva_pkg::ATTR_NORMAL]) begin
            m.normal = 24'd0;
        end
        if (!en[qtva_pkg::ATTR_LIGHT]) begin
            m.light = 32'd0;
        end
        return m;
    endfunction

    // Load the output register when it is empty or being drained
    assign load = head_valid && (!m_tvalid_reg || m_tready);

    // Build the head item's own record
    always_comb begin
        own_rec        = '0;
        own_rec.x_bits = to_float(head.sum_x);
        own_rec.y_bits = to_float(head.sum_y);
        own_rec.z_bits = to_float(head.sum_z);
        own_rec.u      = head.u;
        own_rec.v      = head.v;
        own_rec.color  = head.color;
        own_rec.normal = head.normal;
        own_rec.light  = head.light;
    end

    // Next record to emit for the head item
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            qtva_pkg::ST_LEAD: begin
                if (load && head.expand) begin
                    st_next = qtva_pkg::ST_SECOND;
                end
            end
            qtva_pkg::ST_SECOND: begin
                if (load) begin
                    st_next = qtva_pkg::ST_OWN;
                end
            end
            qtva_pkg::ST_OWN: begin
                if (load) begin
                    st_next = qtva_pkg::ST_LEAD;
                end
            end
            default: begin
                st_next = qtva_pkg::ST_LEAD;
            end
        endcase
    end

    // Select corner replay or own record
    always_comb begin
        is_replay  = 1'b0;
        corner_row = qtva_pkg::CORNER_FIRST_ROW;
        unique case (st_reg)
            qtva_pkg::ST_LEAD: begin
                is_replay = head.expand;
            end
            qtva_pkg::ST_SECOND: begin
                is_replay  = 1'b1;
                corner_row = qtva_pkg::CORNER_THIRD_ROW;
            end
            qtva_pkg::ST_OWN: begin
                is_replay = 1'b0;
            end
            default: begin
                is_replay = 1'b0;
            end
        endcase
    end

    assign pop        = load && !is_replay;
    assign replay_rec = mask_attrs(corner_reg[corner_row], attr_enable);
    assign rec_sel    = is_replay ? replay_rec : own_rec;

    // Restart numbering on the first item of a batch, saturate at the cap
    assign rec_index  = (head.first && (st_reg == qtva_pkg::ST_LEAD)) ? 16'd0 : count_reg;
    assign count_next = !load ? count_reg :
                        (rec_index < qtva_pkg::COUNT_CAP) ? (rec_index + 16'd1) : rec_index;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= qtva_pkg::ST_LEAD;
            count_reg    <= 16'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            count_reg <= count_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Hold the record payload
    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {rec_index, rec_sel.light, rec_sel.normal, rec_sel.color,
                            rec_sel.v, rec_sel.u, rec_sel.z_bits, rec_sel.y_bits,
                            rec_sel.x_bits};
            m_tlast_reg <= !is_replay;
        end
    end

    // Keep the first and third corners of the quad
    always_ff @(posedge aclk) begin
        if (pop && head.keep) begin
            corner_reg[head.keep_row] <= own_rec;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

@@ design/quad_to_triangle_vertex_assembler.sv @@
`default_nettype none

// Channel   Direction  Width  Contents
// s_        in         224    one vertex; s_tuser = first_of_batch
// m_        out        264    one vertex record; m_tlast = last record of the vertex
// APB       in/out     32     six configuration registers at 4*i
//
// Each accepted vertex gives one record, or three for the fourth vertex of a
// split quad; the output register sends one record a cycle while m_tready is
// high and the queue holds an item, so a split quad gives six records in all.
// A vertex's first record reaches m_ through the queue write and then the
// output register; after two replays its own record follows.
// aresetn is synchronous; it clears control state and configuration, not the
// kept quad corners. A four-entry queue lets input and output stall on their own.

module quad_to_triangle_vertex_assembler (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v, color_word, light_word, normal_word
    input  wire logic [qtva_pkg::S_TDATA_W-1:0]  s_tdata,
    // first_of_batch
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // out_x_bits, out_y_bits, out_z_bits, out_u, out_v, out_color,
    // out_normal, out_light, vertex_index
    output logic [qtva_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [qtva_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    logic signed [23:0] x_offset_reg;
    logic signed [23:0] y_offset_reg;
    logic signed [23:0] z_offset_reg;
    logic               quad_mode_reg;
    logic               split_quads_reg;
    logic [3:0]         attr_enable_reg;

    logic                 cfg_wr;
    qtva_pkg::reg_index_t cfg_idx;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    qtva_pkg::entry_t     q_in;
    qtva_pkg::entry_t     q_head;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = qtva_pkg::reg_index_t'(paddr[4:2]);

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_offset_reg    <= 24'sd0;
            y_offset_reg    <= 24'sd0;
            z_offset_reg    <= 24'sd0;
            quad_mode_reg   <= 1'b1;
            split_quads_reg <= 1'b1;
            attr_enable_reg <= 4'd0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                qtva_pkg::REG_X_OFFSET:    x_offset_reg    <= pwdata[23:0];
                qtva_pkg::REG_Y_OFFSET:    y_offset_reg    <= pwdata[23:0];
                qtva_pkg::REG_Z_OFFSET:    z_offset_reg    <= pwdata[23:0];
                qtva_pkg::REG_QUAD_MODE:   quad_mode_reg   <= pwdata[0];
                qtva_pkg::REG_SPLIT_QUADS: split_quads_reg <= pwdata[0];
                qtva_pkg::REG_ATTR_ENABLE: attr_enable_reg <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // Read back configuration
    always_comb begin
        unique case (cfg_idx)
            qtva_pkg::REG_X_OFFSET:    prdata = {8'd0, x_offset_reg};
            qtva_pkg::REG_Y_OFFSET:    prdata = {8'd0, y_offset_reg};
            qtva_pkg::REG_Z_OFFSET:    prdata = {8'd0, z_offset_reg};
            qtva_pkg::REG_QUAD_MODE:   prdata = {31'd0, quad_mode_reg};
            qtva_pkg::REG_SPLIT_QUADS: prdata = {31'd0, split_quads_reg};
            qtva_pkg::REG_ATTR_ENABLE: prdata = {28'd0, attr_enable_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    qtva_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .x_offset    (x_offset_reg),
        .y_offset    (y_offset_reg),
        .z_offset    (z_offset_reg),
        .quad_mode   (quad_mode_reg),
        .split_quads (split_quads_reg),
        .attr_enable (attr_enable_reg),
        .q_full      (q_full),
        .push        (q_push),
        .push_entry  (q_in)
    );

    qtva_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .pop        (q_pop),
        .full       (q_full),
        .empty      (q_empty),
        .head       (q_head)
    );

    qtva_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (!q_empty),
        .head        (q_head),
        .attr_enable (attr_enable_reg),
        .pop         (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

`ifndef SYNTHESIS
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_full)
        else $error("input stalled while queue has room");

    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_replay_followed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("replayed corner not followed by next record");

    a_index_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast && (m_tdata[263:248] != qtva_pkg::COUNT_CAP))
        |=> (m_tdata[263:248] == ($past(m_tdata[263:248]) + 16'd1)))
        else $error("vertex index did not advance within one vertex");
`endif

endmodule

`default_nettype wire
